// File: hw/rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and constants of the adsr envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int LEVEL_WIDTH     = 30;
   localparam int OUT_WIDTH       = 10;
   localparam int PHASE_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 30;
   localparam int SUSTAIN_SHIFT   = LEVEL_WIDTH - OUT_WIDTH;

   // envelope stage, encoded as the phase output
   typedef enum logic [PHASE_WIDTH-1:0] {
      STAGE_ATTACK  = 2'd0,
      STAGE_DECAY   = 2'd1,
      STAGE_RELEASE = 2'd2
   } stage_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTACK_INC  = 3'd0,
      CSR_DECAY_INC   = 3'd1,
      CSR_RELEASE_INC = 3'd2,
      CSR_SUSTAIN     = 3'd3,
      CSR_PEAK        = 3'd4
   } csr_index_type;

   localparam logic [LEVEL_WIDTH-1:0] INC_RESET     = 30'h0010_0000;
   localparam logic [OUT_WIDTH-1:0]   SUSTAIN_RESET = 10'd512;
   localparam logic [LEVEL_WIDTH-1:0] PEAK_RESET    = 30'h3FFF_FFFF;

endpackage

// File: hw/rtl/adsr_req_if.sv
// ----------------------------------------------------------------------------
// adsr_req_if
// tick channel: one gate bit per transaction
// ----------------------------------------------------------------------------
interface adsr_req_if;
   logic valid;
   logic ready;
   logic gate;

   modport source (output valid, output gate, input ready);
   modport sink   (input valid, input gate, output ready);
endinterface

// File: hw/rtl/adsr_rsp_if.sv
// ----------------------------------------------------------------------------
// adsr_rsp_if
// result channel: envelope level and stage per transaction
// ----------------------------------------------------------------------------
interface adsr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [adsr_pkg::OUT_WIDTH-1:0]     env_out;
   logic [adsr_pkg::PHASE_WIDTH-1:0]   phase;

   modport source (output valid, output env_out, output phase, input ready);
   modport sink   (input valid, input env_out, input phase, output ready);
endinterface

// File: hw/rtl/adsr_csr_if.sv
// ----------------------------------------------------------------------------
// adsr_csr_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface adsr_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [adsr_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [adsr_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// attack / decay / release envelope, one step per tick transaction
// ----------------------------------------------------------------------------
// Each tick transaction on req_chan carries the gate bit and advances a 30-bit
// envelope level by one step of the current stage, or on a gate change only
// switches stage; the result transaction on rsp_chan gives the top ten bits of
// the new level and the new stage. One tick is taken per clock cycle: the
// step is a single add or subtract and compare between the level / stage
// registers and the result register, which frees itself in the same cycle it
// is taken, so ticks stream without gaps while rsp_chan.ready is high.
// Increments, sustain level and peak are written through csr_chan, which is
// always ready; writes to indexes beyond the register list are dropped. After
// reset the envelope sits in release at level zero.
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
   input  logic        clock,
   input  logic        reset,
   adsr_req_if.sink    req_chan,
   adsr_rsp_if.source  rsp_chan,
   adsr_csr_if.sink    csr_chan
);

   localparam int LW = adsr_pkg::LEVEL_WIDTH;
   localparam int OW = adsr_pkg::OUT_WIDTH;
   localparam int SH = adsr_pkg::SUSTAIN_SHIFT;

   // configuration registers
   logic [LW-1:0] attack_inc_ff;
   logic [LW-1:0] decay_inc_ff;
   logic [LW-1:0] release_inc_ff;
   logic [OW-1:0] sustain_ff;
   logic [LW-1:0] peak_ff;

   // envelope state
   logic [LW-1:0]        level_ff, level_in;
   adsr_pkg::stage_type  stage_ff, stage_in;

   // result register
   logic                 rsp_valid_ff;
   logic [OW-1:0]        env_out_ff;
   adsr_pkg::stage_type  phase_ff;

   logic req_fire;
   logic rsp_fire;

   // step arithmetic, one extra bit for carry / borrow
   logic [LW:0]   attack_sum;
   logic [LW:0]   decay_diff;
   logic [LW:0]   release_diff;
   logic [LW-1:0] sustain_base;
   logic [LW-1:0] sustain_limit;

   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   // result register can take a new tick when empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_inc_ff  <= adsr_pkg::INC_RESET;
         decay_inc_ff   <= adsr_pkg::INC_RESET;
         release_inc_ff <= adsr_pkg::INC_RESET;
         sustain_ff     <= adsr_pkg::SUSTAIN_RESET;
         peak_ff        <= adsr_pkg::PEAK_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            adsr_pkg::CSR_ATTACK_INC:  attack_inc_ff  <= csr_chan.data[LW-1:0];
            adsr_pkg::CSR_DECAY_INC:   decay_inc_ff   <= csr_chan.data[LW-1:0];
            adsr_pkg::CSR_RELEASE_INC: release_inc_ff <= csr_chan.data[LW-1:0];
            adsr_pkg::CSR_SUSTAIN:     sustain_ff     <= csr_chan.data[OW-1:0];
            adsr_pkg::CSR_PEAK:        peak_ff        <= csr_chan.data[LW-1:0];
            default: begin
               // index beyond the register list: dropped
            end
         endcase
      end
   end

   assign attack_sum    = {1'b0, level_ff} + {1'b0, attack_inc_ff};
   assign decay_diff    = {1'b0, level_ff} - {1'b0, decay_inc_ff};
   assign release_diff  = {1'b0, level_ff} - {1'b0, release_inc_ff};
   // sustain in level units, and the same plus the slack below the next step
   assign sustain_base  = {sustain_ff, {SH{1'b0}}};
   assign sustain_limit = {sustain_ff, {SH{1'b1}}};

   // next envelope state for the tick on req_chan
   always_comb begin
      level_in = level_ff;
      stage_in = stage_ff;
      unique case (stage_ff)
         adsr_pkg::STAGE_ATTACK: begin
            if (req_chan.gate) begin
               // saturate at the peak and hand over to decay
               if (attack_sum >= {1'b0, peak_ff}) begin
                  level_in = peak_ff;
                  stage_in = adsr_pkg::STAGE_DECAY;
               end else begin
                  level_in = attack_sum[LW-1:0];
               end
            end else begin
               stage_in = adsr_pkg::STAGE_RELEASE;
            end
         end
         adsr_pkg::STAGE_DECAY: begin
            if (req_chan.gate) begin
               // step down while clear of sustain, else snap to sustain
               if (!decay_diff[LW] && (decay_diff[LW-1:0] > sustain_limit)) begin
                  level_in = decay_diff[LW-1:0];
               end else begin
                  level_in = sustain_base;
               end
            end else begin
               stage_in = adsr_pkg::STAGE_RELEASE;
            end
         end
         adsr_pkg::STAGE_RELEASE: begin
            if (!req_chan.gate) begin
               // step down, floor at zero
               if (!release_diff[LW] && (release_diff[LW-1:0] != '0)) begin
                  level_in = release_diff[LW-1:0];
               end else begin
                  level_in = '0;
               end
            end else begin
               stage_in = adsr_pkg::STAGE_ATTACK;
            end
         end
         default: begin
            // unused stage code: hold
         end
      endcase
   end

   // envelope state advances only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         stage_ff <= adsr_pkg::STAGE_RELEASE;
      end else if (req_fire) begin
         level_ff <= level_in;
         stage_ff <= stage_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         env_out_ff <= level_in[LW-1:SH];
         phase_ff   <= stage_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.env_out = env_out_ff;
   assign rsp_chan.phase   = phase_ff;

`ifndef SYNTH
   // every accepted tick leaves a result waiting
   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // a pending result always mirrors the current envelope state
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_chan.env_out == level_ff[LW-1:SH]) &&
                       (rsp_chan.phase == stage_ff))
      else $error("result does not match envelope state");

   // release with gate off never raises the level
   a_release_falls: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (stage_ff == adsr_pkg::STAGE_RELEASE) && !req_chan.gate)
      |=> (level_ff <= $past(level_ff)))
      else $error("release step raised the level");

   // decay with gate on never drops below sustain
   a_decay_floor: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (stage_ff == adsr_pkg::STAGE_DECAY) && req_chan.gate)
      |=> (level_ff[LW-1:SH] >= sustain_ff))
      else $error("decay step went below sustain");
`endif

endmodule
